// ----- hw/rtl/lsp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the latency statistics monitor.
// No dependencies; imported by the controller, datapath and top level.
package lsp_pkg;

    // Field widths
    localparam int LAT_W   = 48;
    localparam int CTR_W   = 32;
    localparam int BYTE_W  = 32;
    localparam int SUM_W   = 64;
    localparam int MODE_W  = 2;

    // Command codes
    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    // I/O mode codes
    localparam logic [MODE_W-1:0] MODE_DIRECT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BUFFERED = 2'd1;

    // floor(n*P/100) = (n * P * ceil(2^32/100)) >> 32, exact for n*P < 2^30
    localparam int unsigned RECIP_SH = 32;
    localparam logic [31:0] K_P50 = 32'd2147483650;   // 50 * 42949673
    localparam logic [31:0] K_P95 = 32'd4080218935;   // 95 * 42949673
    localparam logic [31:0] K_P99 = 32'd4252017627;   // 99 * 42949673

    typedef enum logic [2:0] {
        S_IDLE,
        S_RANK,
        S_CRD,
        S_CWAIT,
        S_SCAN,
        S_DRAIN,
        S_EVAL,
        S_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic rec;       // apply a record beat
        logic rank_ld;   // compute target ranks, clear candidate index
        logic cand_rd;   // read candidate entry
        logic cand_ld;   // latch candidate, clear scan counters
        logic scan_rd;   // read next scan entry
        logic eval;      // check candidate against ranks, advance
        logic pct_wr;    // commit percentiles
        logic emit;      // strobe a result next cycle
    } t_ctl;

    // Datapath to controller status
    typedef struct packed {
        logic few;       // fewer than two samples
        logic last_j;    // scan index at last sample
        logic last_i;    // candidate index at last sample
    } t_sts;

endpackage

// ----- hw/rtl/lsp_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/lsp_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for the latency monitor: record beats and the rank-by-count report.
// Depends on lsp_pkg.
module lsp_ctrl
    import lsp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_cmd,
    input  t_sts i_sts,
    output logic o_busy,
    output t_ctl o_ctl
);

    t_state r_state, n_state;
    logic   accept;

    assign accept = i_start && (r_state == S_IDLE);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_cmd == CMD_REPORT && !i_sts.few) begin
                    n_state = S_RANK;
                end
            end
            S_RANK:  n_state = S_CRD;
            S_CRD:   n_state = S_CWAIT;
            S_CWAIT: n_state = S_SCAN;
            S_SCAN: begin
                if (i_sts.last_j) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_EVAL;
            S_EVAL: begin
                n_state = i_sts.last_i ? S_DONE : S_CRD;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_ctl  = '0;
        o_busy = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd == CMD_RECORD) begin
                        o_ctl.rec  = 1'b1;
                        o_ctl.emit = 1'b1;
                    end else if (i_sts.few) begin
                        o_ctl.emit = 1'b1;
                    end
                end
            end
            S_RANK:  o_ctl.rank_ld = 1'b1;
            S_CRD:   o_ctl.cand_rd = 1'b1;
            S_CWAIT: o_ctl.cand_ld = 1'b1;
            S_SCAN:  o_ctl.scan_rd = 1'b1;
            S_DRAIN: o_ctl = '0;
            S_EVAL:  o_ctl.eval = 1'b1;
            S_DONE: begin
                o_ctl.pct_wr = 1'b1;
                o_ctl.emit   = 1'b1;
            end
            default: o_ctl = '0;
        endcase
    end

endmodule

// ----- hw/rtl/lsp_dpath.sv -----
`timescale 1ns / 1ps
// Datapath: counters, min/max, sample ring and order-statistic search.
// Depends on lsp_pkg and lsp_ram.
module lsp_dpath
    import lsp_pkg::*;
#(
    parameter int RING_DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctl              i_ctl,
    input  logic [LAT_W-1:0]  i_frame_time,
    input  logic [BYTE_W-1:0] i_byte_count,
    input  logic [MODE_W-1:0] i_mode_code,
    input  logic              i_ok_flag,
    output t_sts              o_sts,
    output logic              o_valid,
    output logic [CTR_W-1:0]  o_frames_done,
    output logic [CTR_W-1:0]  o_frames_good,
    output logic [CTR_W-1:0]  o_frames_bad,
    output logic [CTR_W-1:0]  o_direct_count,
    output logic [CTR_W-1:0]  o_buffered_count,
    output logic [SUM_W-1:0]  o_bytes_total,
    output logic [LAT_W-1:0]  o_lat_min,
    output logic [LAT_W-1:0]  o_lat_max,
    output logic [LAT_W-1:0]  o_pct_50,
    output logic [LAT_W-1:0]  o_pct_95,
    output logic [LAT_W-1:0]  o_pct_99,
    output logic [MODE_W-1:0] o_last_mode
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int PW = CW + 32;

    // Statistics registers
    logic [CTR_W-1:0]  r_done, r_good, r_bad, r_direct, r_buffered;
    logic [SUM_W-1:0]  r_bytes;
    logic [LAT_W-1:0]  r_min, r_max;
    logic [LAT_W-1:0]  r_p50, r_p95, r_p99;
    logic [MODE_W-1:0] r_mode;
    logic              r_valid;

    // Ring bookkeeping
    logic [AW-1:0] r_ptr;
    logic [CW-1:0] r_cnt;

    // Search state
    logic [CW-1:0]    r_i, r_j;
    logic [CW-1:0]    r_k50, r_k95, r_k99;
    logic [CW-1:0]    r_lt, r_le;
    logic [LAT_W-1:0] r_cand;
    logic [LAT_W-1:0] r_f50, r_f95, r_f99;
    logic             r_acc_v;

    logic             ft_nz;
    logic             ring_we;
    logic [AW-1:0]    raddr;
    logic [LAT_W-1:0] rdata;
    logic [PW-1:0]    prod50, prod95, prod99;
    logic [CW-1:0]    cnt_m1;

    assign ft_nz   = (i_frame_time != '0);
    assign ring_we = i_ctl.rec && ft_nz;
    assign raddr   = i_ctl.cand_rd ? r_i[AW-1:0] : r_j[AW-1:0];
    assign cnt_m1  = r_cnt - CW'(1);

    lsp_ram #(
        .WIDTH (LAT_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_ptr),
        .i_wdata (i_frame_time),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Target ranks: constant multiply by reciprocal
    assign prod50 = PW'(r_cnt) * PW'(K_P50);
    assign prod95 = PW'(r_cnt) * PW'(K_P95);
    assign prod99 = PW'(r_cnt) * PW'(K_P99);

    // Control state: counters, byte total, min/max, percentiles, ring pointer, strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done     <= '0;
            r_good     <= '0;
            r_bad      <= '0;
            r_direct   <= '0;
            r_buffered <= '0;
            r_bytes    <= '0;
            r_min      <= '1;
            r_max      <= '0;
            r_p50      <= '0;
            r_p95      <= '0;
            r_p99      <= '0;
            r_mode     <= '0;
            r_ptr      <= '0;
            r_cnt      <= '0;
            r_valid    <= 1'b0;
            r_acc_v    <= 1'b0;
        end else begin
            r_valid <= i_ctl.emit;
            r_acc_v <= i_ctl.scan_rd;
            if (i_ctl.rec) begin
                r_done  <= r_done + CTR_W'(1);
                r_bytes <= r_bytes + SUM_W'(i_byte_count);
                r_mode  <= i_mode_code;
                if (i_ok_flag) begin
                    r_good <= r_good + CTR_W'(1);
                end else begin
                    r_bad <= r_bad + CTR_W'(1);
                end
                if (i_mode_code == MODE_DIRECT) begin
                    r_direct <= r_direct + CTR_W'(1);
                end else if (i_mode_code == MODE_BUFFERED) begin
                    r_buffered <= r_buffered + CTR_W'(1);
                end
                if (ft_nz && i_frame_time < r_min) begin
                    r_min <= i_frame_time;
                end
                if (i_frame_time > r_max) begin
                    r_max <= i_frame_time;
                end
                if (ft_nz) begin
                    r_ptr <= (r_ptr == AW'(RING_DEPTH - 1)) ? '0 : r_ptr + AW'(1);
                    if (r_cnt != CW'(RING_DEPTH)) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
            end
            if (i_ctl.pct_wr) begin
                r_p50 <= r_f50;
                r_p95 <= r_f95;
                r_p99 <= r_f99;
            end
        end
    end

    // Order-statistic search: count entries below / not above each candidate
    always_ff @(posedge i_clk) begin
        if (i_ctl.rank_ld) begin
            r_k50 <= prod50[RECIP_SH +: CW];
            r_k95 <= prod95[RECIP_SH +: CW];
            r_k99 <= prod99[RECIP_SH +: CW];
            r_i   <= '0;
        end
        if (i_ctl.cand_ld) begin
            r_cand <= rdata;
            r_lt   <= '0;
            r_le   <= '0;
            r_j    <= '0;
        end
        if (i_ctl.scan_rd) begin
            r_j <= r_j + CW'(1);
        end
        if (r_acc_v) begin
            if (rdata < r_cand) begin
                r_lt <= r_lt + CW'(1);
            end
            if (rdata <= r_cand) begin
                r_le <= r_le + CW'(1);
            end
        end
        if (i_ctl.eval) begin
            r_i <= r_i + CW'(1);
            if (r_lt <= r_k50 && r_k50 < r_le) begin
                r_f50 <= r_cand;
            end
            if (r_lt <= r_k95 && r_k95 < r_le) begin
                r_f95 <= r_cand;
            end
            if (r_lt <= r_k99 && r_k99 < r_le) begin
                r_f99 <= r_cand;
            end
        end
    end

    // Status
    assign o_sts.few    = (r_cnt < CW'(2));
    assign o_sts.last_j = (r_j == cnt_m1);
    assign o_sts.last_i = (r_i == cnt_m1);

    assign o_valid          = r_valid;
    assign o_frames_done    = r_done;
    assign o_frames_good    = r_good;
    assign o_frames_bad     = r_bad;
    assign o_direct_count   = r_direct;
    assign o_buffered_count = r_buffered;
    assign o_bytes_total    = r_bytes;
    assign o_lat_min        = r_min;
    assign o_lat_max        = r_max;
    assign o_pct_50         = r_p50;
    assign o_pct_95         = r_p95;
    assign o_pct_99         = r_p99;
    assign o_last_mode      = r_mode;

    // Checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(RING_DEPTH))
        else $error("sample count above ring depth");
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= AW'(RING_DEPTH - 1))
        else $error("ring pointer out of range");
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_min <= r_max))
        else $error("min latency above max latency");
    a_rank_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_ctl.rank_ld) |-> (r_k99 < r_cnt && r_k50 <= r_k95))
        else $error("target rank out of range");

endmodule

// ----- hw/rtl/latency_stats_percentile_monitor.sv -----
`timescale 1ns / 1ps
// Top level of the running latency statistics monitor.
// Depends on lsp_pkg, lsp_ctrl, lsp_dpath (which holds lsp_ram).
//
// Usage:
//   A beat is accepted on a rising edge with start high and busy low.
//   i_cmd = 0 records one frame: counters, byte total, min/max latency and
//   the ring of the last RING_DEPTH nonzero latencies update at that edge.
//   i_cmd = 1 ranks the ring and refreshes p50/p95/p99.
//   Each beat yields one result: o_valid is high for exactly one cycle
//   with all statistics on the o_ ports; the receiver cannot stall it.
// Timing:
//   Record: result strobed in the cycle after accept, busy stays low, so a
//   record can be taken every cycle.
//   Report with n >= 2 samples: for each of the n candidates the ring is
//   scanned once through the single RAM read port while busy is high; the
//   result is strobed in the first cycle with busy low again. With fewer
//   than two samples the result follows in the cycle after accept and
//   percentiles keep old values.
// Reset:
//   Synchronous, active low. Counters, min (all ones), max, percentiles
//   and ring pointer/count clear; ring contents are not cleared.
module latency_stats_percentile_monitor
    import lsp_pkg::*;
#(
    parameter int RING_DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_cmd,
    input  logic [LAT_W-1:0]  i_frame_time,
    input  logic [BYTE_W-1:0] i_byte_count,
    input  logic [MODE_W-1:0] i_mode_code,
    input  logic              i_ok_flag,
    output logic              o_valid,
    output logic [CTR_W-1:0]  o_frames_done,
    output logic [CTR_W-1:0]  o_frames_good,
    output logic [CTR_W-1:0]  o_frames_bad,
    output logic [CTR_W-1:0]  o_direct_count,
    output logic [CTR_W-1:0]  o_buffered_count,
    output logic [SUM_W-1:0]  o_bytes_total,
    output logic [LAT_W-1:0]  o_lat_min,
    output logic [LAT_W-1:0]  o_lat_max,
    output logic [LAT_W-1:0]  o_pct_50,
    output logic [LAT_W-1:0]  o_pct_95,
    output logic [LAT_W-1:0]  o_pct_99,
    output logic [MODE_W-1:0] o_last_mode
);

    t_ctl ctl;
    t_sts sts;

    lsp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_sts   (sts),
        .o_busy  (busy),
        .o_ctl   (ctl)
    );

    lsp_dpath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .i_frame_time     (i_frame_time),
        .i_byte_count     (i_byte_count),
        .i_mode_code      (i_mode_code),
        .i_ok_flag        (i_ok_flag),
        .o_sts            (sts),
        .o_valid          (o_valid),
        .o_frames_done    (o_frames_done),
        .o_frames_good    (o_frames_good),
        .o_frames_bad     (o_frames_bad),
        .o_direct_count   (o_direct_count),
        .o_buffered_count (o_buffered_count),
        .o_bytes_total    (o_bytes_total),
        .o_lat_min        (o_lat_min),
        .o_lat_max        (o_lat_max),
        .o_pct_50         (o_pct_50),
        .o_pct_95         (o_pct_95),
        .o_pct_99         (o_pct_99),
        .o_last_mode      (o_last_mode)
    );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for latency_stats_percentile_monitor.
// Drives record/report beats, predicts every result with an internal model
// of the counters, ring and percentile ranking, and compares each strobe.
module testbench
    import lsp_pkg::*;
();

    localparam int DEPTH      = 256;
    localparam int LIMIT      = 3000000;
    localparam int RANK_BUDGET = 700000;   // cycles we allow reports to spend

    typedef struct {
        logic [CTR_W-1:0]  done_n;
        logic [CTR_W-1:0]  good_n;
        logic [CTR_W-1:0]  bad_n;
        logic [CTR_W-1:0]  direct_n;
        logic [CTR_W-1:0]  buffered_n;
        logic [SUM_W-1:0]  bytes_sum;
        logic [LAT_W-1:0]  lat_lo;
        logic [LAT_W-1:0]  lat_hi;
        logic [LAT_W-1:0]  p50;
        logic [LAT_W-1:0]  p95;
        logic [LAT_W-1:0]  p99;
        logic [MODE_W-1:0] mode;
    } t_stats;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_cmd;
    logic [LAT_W-1:0]  i_frame_time;
    logic [BYTE_W-1:0] i_byte_count;
    logic [MODE_W-1:0] i_mode_code;
    logic              i_ok_flag;
    logic              o_valid;
    logic [CTR_W-1:0]  o_frames_done;
    logic [CTR_W-1:0]  o_frames_good;
    logic [CTR_W-1:0]  o_frames_bad;
    logic [CTR_W-1:0]  o_direct_count;
    logic [CTR_W-1:0]  o_buffered_count;
    logic [SUM_W-1:0]  o_bytes_total;
    logic [LAT_W-1:0]  o_lat_min;
    logic [LAT_W-1:0]  o_lat_max;
    logic [LAT_W-1:0]  o_pct_50;
    logic [LAT_W-1:0]  o_pct_95;
    logic [LAT_W-1:0]  o_pct_99;
    logic [MODE_W-1:0] o_last_mode;

    latency_stats_percentile_monitor #(.RING_DEPTH(DEPTH)) dut (.*);

    // Model state
    t_stats           model;
    logic [LAT_W-1:0] lat_ring [DEPTH];
    logic [LAT_W-1:0] ranked [DEPTH];
    int               ring_wr;
    int               ring_fill;

    t_stats pending_stats [$];
    int     err_cnt;
    int     cycles;
    int     rec_cnt;
    int     rep_cnt;
    int     rank_spent;
    int     top_fill;
    int     idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Rank the valid ring entries and refresh the percentile registers
    task automatic rank_ring();
        int n;
        logic [LAT_W-1:0] v;
        int j;
        n = ring_fill;
        if (n < 2) return;
        for (int i = 0; i < n; i++) ranked[i] = lat_ring[i];
        for (int i = 1; i < n; i++) begin
            v = ranked[i];
            j = i;
            while (j > 0 && ranked[j-1] > v) begin
                ranked[j] = ranked[j-1];
                j--;
            end
            ranked[j] = v;
        end
        model.p50 = ranked[(n * 50) / 100];
        model.p95 = ranked[(n * 95) / 100];
        model.p99 = ranked[(n * 99) / 100];
    endtask

    task automatic apply_beat(logic cmd, logic [LAT_W-1:0] ft, logic [BYTE_W-1:0] bc,
                              logic [MODE_W-1:0] md, logic ok);
        if (cmd == CMD_REPORT) begin
            rank_ring();
        end else begin
            model.done_n++;
            model.bytes_sum += SUM_W'(bc);
            model.mode = md;
            if (ok) model.good_n++;
            else model.bad_n++;
            if (md == MODE_DIRECT) model.direct_n++;
            else if (md == MODE_BUFFERED) model.buffered_n++;
            if (ft != 0 && ft < model.lat_lo) model.lat_lo = ft;
            if (ft > model.lat_hi) model.lat_hi = ft;
            if (ft != 0) begin
                lat_ring[ring_wr] = ft;
                ring_wr = (ring_wr + 1) % DEPTH;
                if (ring_fill < DEPTH) ring_fill++;
            end
        end
        pending_stats.push_back(model);
    endtask

    // Send one beat; start stays high until busy is seen low at an edge
    task automatic send_beat(logic cmd, logic [LAT_W-1:0] ft, logic [BYTE_W-1:0] bc,
                             logic [MODE_W-1:0] md, logic ok);
        start        <= 1'b1;
        i_cmd        <= cmd;
        i_frame_time <= ft;
        i_byte_count <= bc;
        i_mode_code  <= md;
        i_ok_flag    <= ok;
        do @(posedge i_clk); while (busy);
        apply_beat(cmd, ft, bc, md, ok);
        if (cmd == CMD_REPORT) begin
            rep_cnt++;
            if (ring_fill >= 2) rank_spent += ring_fill * (ring_fill + 4) + 2;
            if (ring_fill > top_fill) top_fill = ring_fill;
        end else begin
            rec_cnt++;
        end
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic void cmp_field(string name, logic [SUM_W-1:0] exp_v,
                                      logic [SUM_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    // Result checker: every strobe must match the oldest prediction
    always @(posedge i_clk) begin
        t_stats e;
        if (i_rst_n && o_valid) begin
            if (pending_stats.size() == 0) begin
                $error("result strobe with no beat outstanding");
                err_cnt++;
            end else begin
                e = pending_stats.pop_front();
                cmp_field("frames_done", SUM_W'(e.done_n), SUM_W'(o_frames_done));
                cmp_field("frames_good", SUM_W'(e.good_n), SUM_W'(o_frames_good));
                cmp_field("frames_bad", SUM_W'(e.bad_n), SUM_W'(o_frames_bad));
                cmp_field("direct_count", SUM_W'(e.direct_n), SUM_W'(o_direct_count));
                cmp_field("buffered_count", SUM_W'(e.buffered_n),
                          SUM_W'(o_buffered_count));
                cmp_field("bytes_total", e.bytes_sum, o_bytes_total);
                cmp_field("lat_min", SUM_W'(e.lat_lo), SUM_W'(o_lat_min));
                cmp_field("lat_max", SUM_W'(e.lat_hi), SUM_W'(o_lat_max));
                cmp_field("pct_50", SUM_W'(e.p50), SUM_W'(o_pct_50));
                cmp_field("pct_95", SUM_W'(e.p95), SUM_W'(o_pct_95));
                cmp_field("pct_99", SUM_W'(e.p99), SUM_W'(o_pct_99));
                cmp_field("last_mode", SUM_W'(e.mode), SUM_W'(o_last_mode));
            end
        end
    end

    // Reports before any sample and with a single sample keep old percentiles
    task automatic test_sparse_report();
        send_beat(CMD_REPORT, '1, '1, 2'd3, 1'b1);
        send_beat(CMD_RECORD, 48'd0, 32'd0, MODE_DIRECT, 1'b1);
        send_beat(CMD_REPORT, 48'd0, 32'd0, MODE_DIRECT, 1'b0);
        send_beat(CMD_RECORD, 48'd700, 32'd64, MODE_BUFFERED, 1'b0);
        send_beat(CMD_REPORT, 48'd5, 32'd1, MODE_BUFFERED, 1'b1);
    endtask

    // Field extremes, every mode code, success and failure
    task automatic test_field_extremes();
        send_beat(CMD_RECORD, '1, '1, 2'd2, 1'b1);
        send_beat(CMD_RECORD, 48'd1, '1, 2'd3, 1'b0);
        send_beat(CMD_RECORD, 48'd0, 32'd0, 2'd3, 1'b0);
        send_beat(CMD_RECORD, 48'h5555_5555_5555, 32'hAAAA_AAAA, MODE_DIRECT, 1'b1);
        send_beat(CMD_RECORD, 48'hAAAA_AAAA_AAAA, 32'h5555_5555, MODE_BUFFERED, 1'b1);
        send_beat(CMD_REPORT, 48'd0, 32'd0, MODE_DIRECT, 1'b0);
    endtask

    // Small ring with duplicates, ranked back to back
    task automatic test_small_ranking();
        send_beat(CMD_RECORD, 48'd700, 32'd10, MODE_DIRECT, 1'b1);
        send_beat(CMD_RECORD, 48'd3, 32'd10, MODE_BUFFERED, 1'b1);
        send_beat(CMD_REPORT, 48'd0, 32'd0, MODE_DIRECT, 1'b0);
        send_beat(CMD_REPORT, 48'd0, 32'd0, MODE_DIRECT, 1'b0);
        send_beat(CMD_RECORD, 48'd3, 32'd10, MODE_DIRECT, 1'b0);
        send_beat(CMD_REPORT, 48'd0, 32'd0, MODE_DIRECT, 1'b0);
        drain_results();
    endtask

    // Random traffic; zero_pct controls how fast the ring fills
    task automatic test_random(int beats, int zero_pct);
        logic [LAT_W-1:0] ft;
        logic             cmd;
        int               sel;
        int               cost;
        for (int k = 0; k < beats; k++) begin
            cost = (ring_fill + 1) * (ring_fill + 5) + 2;
            if (ring_fill <= 64) cmd = ($urandom_range(11) == 0);
            else cmd = ($urandom_range(49) == 0) && (rank_spent + cost < RANK_BUDGET);
            sel = $urandom_range(99);
            if (sel < zero_pct) ft = '0;
            else if (sel < zero_pct + (100 - zero_pct) / 2) ft = LAT_W'($urandom_range(1, 40));
            else if ($urandom_range(19) == 0) ft = '1;
            else ft = LAT_W'({$urandom, $urandom});
            send_beat(cmd, ft, $urandom, MODE_W'($urandom_range(3)), 1'($urandom));
            if ($urandom_range(299) == 0) drain_results();
        end
        drain_results();
    endtask

    initial begin
        cycles        = 0;
        err_cnt       = 0;
        rec_cnt       = 0;
        rep_cnt       = 0;
        rank_spent    = 0;
        top_fill      = 0;
        idle_pct      = 0;
        ring_wr       = 0;
        ring_fill     = 0;
        model.done_n     = '0;
        model.good_n     = '0;
        model.bad_n      = '0;
        model.direct_n   = '0;
        model.buffered_n = '0;
        model.bytes_sum  = '0;
        model.lat_lo     = '1;
        model.lat_hi     = '0;
        model.p50        = '0;
        model.p95        = '0;
        model.p99        = '0;
        model.mode       = '0;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_cmd        <= CMD_RECORD;
        i_frame_time <= '0;
        i_byte_count <= '0;
        i_mode_code  <= MODE_DIRECT;
        i_ok_flag    <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_sparse_report();
        test_field_extremes();
        test_small_ranking();
        idle_pct = 33;
        test_random(500, 80);
        idle_pct = 61;
        test_random(500, 20);
        idle_pct = 0;
        test_random(530, 20);

        drain_results();
        $display("Covered %0d record beats and %0d report beats", rec_cnt, rep_cnt);
        $display("Largest ring ranked: %0d samples, %0d cycles of ranking", top_fill,
                 rank_spent);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/lsp_pkg.sv
hw/rtl/lsp_ram.sv
hw/rtl/lsp_ctrl.sv
hw/rtl/lsp_dpath.sv
hw/rtl/latency_stats_percentile_monitor.sv
tb/testbench.sv
